// ===== src/sacl_pkg.sv =====
// Shared constants, types and helpers of the set-associative LRU tag store.
`default_nettype none

package sacl_pkg;

   localparam int SETS = 1024;
   localparam int WAYS = 16;

   localparam int ADDR_W    = 48;
   localparam int TID_W     = 6;
   localparam int CAT_W     = 4;
   localparam int STAMP_W   = 32;
   localparam int HITS_W    = 32;
   localparam int WAY_OUT_W = 4;

   localparam int SET_AW  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LVLS    = $clog2(WAYS);
   localparam int WAYS_P2 = 1 << LVLS;
   localparam int LVL_W   = (LVLS > 0) ? $clog2(LVLS + 1) : 1;

   localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
   localparam logic [HITS_W-1:0]  HITS_MAX  = {HITS_W{1'b1}};

   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [STAMP_W-1:0] stamp;
      logic [HITS_W-1:0]  hits;
      logic [TID_W-1:0]   owner;
      logic [CAT_W-1:0]   cat;
   } line_type;

   typedef line_type [WAYS-1:0] row_type;

   typedef logic [WAYS-1:0][STAMP_W-1:0] stamp_vec_type;

   typedef struct packed {
      logic [WAYS-1:0]    valid;
      logic [STAMP_W-1:0] clock;
   } status_type;

   typedef struct packed {
      logic [WAY_W-1:0]   way;
      logic [STAMP_W-1:0] stamp;
   } cand_type;

   localparam int ROW_W  = $bits(row_type);
   localparam int STAT_W = $bits(status_type);

   function automatic logic [SET_AW-1:0] set_of(input logic [ADDR_W-1:0] a);
      if (SETS > 1) begin
         return a[SET_AW-1:0];
      end else begin
         return '0;
      end
   endfunction

endpackage

`default_nettype wire

// ===== src/sacl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/sacl_lru_search.sv =====
// Oldest-stamp search over one set: pairwise reduction, one tree level per cycle.
`default_nettype none

module sacl_lru_search
   import sacl_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire stamp_vec_type    stamps,
   output logic                  done,
   output logic [WAY_W-1:0]      victim_way
);

   cand_type [WAYS_P2-1:0] cand_ff, cand_in;
   logic     [LVL_W-1:0]   lvl_ff, lvl_in;

   always_comb begin
      cand_in = cand_ff;
      lvl_in  = lvl_ff;
      if (start) begin
         for (int i = 0; i < WAYS_P2; i++) begin
            if (i < WAYS) begin
               cand_in[i] = '{way: WAY_W'(i), stamp: stamps[i]};
            end else begin
               // padding never wins: it is never strictly older
               cand_in[i] = '{way: '0, stamp: STAMP_MAX};
            end
         end
         lvl_in = LVL_W'(LVLS);
      end else if (lvl_ff != '0) begin
         // lower index keeps ties
         for (int i = 0; i < WAYS_P2 / 2; i++) begin
            if (cand_ff[2*i+1].stamp < cand_ff[2*i].stamp) begin
               cand_in[i] = cand_ff[2*i+1];
            end else begin
               cand_in[i] = cand_ff[2*i];
            end
         end
         lvl_in = lvl_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      if (reset) begin
         lvl_ff <= '0;
      end else begin
         lvl_ff <= lvl_in;
      end
   end

   assign done       = (lvl_ff == '0);
   assign victim_way = cand_ff[0].way;

endmodule

`default_nettype wire

// ===== src/set_assoc_lru_cache_tags.sv =====
// Top level of the set-associative tag store with timestamp LRU replacement.
// Hit or fill: the result is registered as the lookup state ends; it waits there while the result register is full.
// Full-set miss: the lookup hands the stamps to the oldest-stamp tree; the result is registered once it is done.
// One item in flight at a time; a waiting result does not block the next transfer in.
// Reset: synchronous; then a clearing pass over all SETS sets (1024) zeroes valid bits and
// set clocks, one set per cycle, with req_ready held low.
`default_nettype none

module set_assoc_lru_cache_tags
   import sacl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [ADDR_W-1:0]    req_block_address,
   input  wire logic [TID_W-1:0]     req_thread_id,
   input  wire logic [CAT_W-1:0]     req_access_category,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_hit,
   output logic [WAY_OUT_W-1:0]      rsp_way_used,
   output logic                      rsp_filled_empty,
   output logic                      rsp_evicted_valid,
   output logic [ADDR_W-1:0]         rsp_evicted_address,
   output logic [HITS_W-1:0]         rsp_evicted_hits,
   output logic [TID_W-1:0]          rsp_evicted_owner,
   output logic [CAT_W-1:0]          rsp_evicted_category
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_SRCH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // request held for the lookup
   logic [ADDR_W-1:0] req_addr_ff;
   logic [TID_W-1:0]  req_tid_ff;
   logic [CAT_W-1:0]  req_cat_ff;
   logic [SET_AW-1:0] set_ff;

   // clearing pass after reset
   logic              clr_busy_ff;
   logic [SET_AW-1:0] clr_idx_ff;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [WAY_OUT_W-1:0] rsp_way_ff;
   logic                 rsp_filled_ff;
   logic                 rsp_ev_valid_ff;
   logic [ADDR_W-1:0]    rsp_ev_addr_ff;
   logic [HITS_W-1:0]    rsp_ev_hits_ff;
   logic [TID_W-1:0]     rsp_ev_owner_ff;
   logic [CAT_W-1:0]     rsp_ev_cat_ff;

   logic              accept;
   logic              out_free;
   logic              finish;
   logic              full_miss;
   logic              hit_any;
   logic              empty_any;
   logic              is_hit;
   logic [WAY_W-1:0]  hit_way;
   logic [WAY_W-1:0]  empty_way;
   logic [WAY_W-1:0]  sel_way;
   logic [WAY_W+WAY_OUT_W-1:0] way_ext;
   logic [STAMP_W-1:0] now_stamp;

   status_type    stat_rd, stat_wr, stat_wdata;
   row_type       row_rd, row_wr;
   line_type      old_line, new_line;
   stamp_vec_type stamps;

   logic              stat_we;
   logic [SET_AW-1:0] stat_waddr;

   logic              srch_start;
   logic              srch_done;
   logic [WAY_W-1:0]  victim_way;

   // ---------------------------------------------------------------
   // Handshake: take a request only when idle and the clearing pass is over
   // ---------------------------------------------------------------
   assign req_ready = (state_ff == ST_IDLE) && !clr_busy_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------
   // Memories: both are read at the request transfer, written back at finish
   // ---------------------------------------------------------------
   logic [STAT_W-1:0] stat_rd_bits;
   logic [ROW_W-1:0]  row_rd_bits;

   sacl_ram #(
      .WIDTH (STAT_W),
      .DEPTH (SETS)
   ) u_status_ram (
      .clock   (clock),
      .wr_en   (stat_we),
      .wr_addr (stat_waddr),
      .wr_data (stat_wdata),
      .rd_en   (accept),
      .rd_addr (set_of(req_block_address)),
      .rd_data (stat_rd_bits)
   );

   sacl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (finish),
      .wr_addr (set_ff),
      .wr_data (row_wr),
      .rd_en   (accept),
      .rd_addr (set_of(req_block_address)),
      .rd_data (row_rd_bits)
   );

   assign stat_rd = stat_rd_bits;
   assign row_rd  = row_rd_bits;

   // ---------------------------------------------------------------
   // Lookup: advance the set clock, compare tags, find the first empty way
   // ---------------------------------------------------------------
   assign now_stamp = (stat_rd.clock == STAMP_MAX) ? STAMP_MAX
                                                   : stat_rd.clock + STAMP_W'(1);

   always_comb begin
      hit_any   = 1'b0;
      hit_way   = '0;
      empty_any = 1'b0;
      empty_way = '0;
      // scan downward so the lowest matching way wins
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (stat_rd.valid[w] && (row_rd[w].addr == req_addr_ff)) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!stat_rd.valid[w]) begin
            empty_any = 1'b1;
            empty_way = WAY_W'(w);
         end
      end
   end

   assign full_miss = !hit_any && !empty_any;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         stamps[w] = row_rd[w].stamp;
      end
   end

   // Full set: hand the stamps to the oldest-stamp search
   assign srch_start = (state_ff == ST_LOOK) && full_miss;

   sacl_lru_search u_lru_search (
      .clock      (clock),
      .reset      (reset),
      .start      (srch_start),
      .stamps     (stamps),
      .done       (srch_done),
      .victim_way (victim_way)
   );

   // ---------------------------------------------------------------
   // Finish: write back the set row and load the result register
   // ---------------------------------------------------------------
   assign finish = out_free &&
                   (((state_ff == ST_LOOK) && !full_miss) ||
                    ((state_ff == ST_SRCH) && srch_done));

   assign is_hit = (state_ff == ST_LOOK) && hit_any;

   always_comb begin
      if (state_ff == ST_SRCH) begin
         sel_way = victim_way;
      end else if (hit_any) begin
         sel_way = hit_way;
      end else begin
         sel_way = empty_way;
      end
   end

   assign old_line = row_rd[sel_way];

   always_comb begin
      if (is_hit) begin
         // keep address and category; bump hits, take owner, restamp
         new_line       = old_line;
         new_line.hits  = (old_line.hits == HITS_MAX) ? HITS_MAX
                                                      : old_line.hits + HITS_W'(1);
         new_line.owner = req_tid_ff;
         new_line.stamp = now_stamp;
      end else begin
         new_line.addr  = req_addr_ff;
         new_line.stamp = now_stamp;
         new_line.hits  = '0;
         new_line.owner = req_tid_ff;
         new_line.cat   = req_cat_ff;
      end
   end

   always_comb begin
      row_wr          = row_rd;
      row_wr[sel_way] = new_line;
      stat_wr                = stat_rd;
      stat_wr.valid[sel_way] = 1'b1;
      stat_wr.clock          = now_stamp;
   end

   // Status write port is shared by the clearing pass and the write-back
   always_comb begin
      if (clr_busy_ff) begin
         stat_we    = 1'b1;
         stat_waddr = clr_idx_ff;
         stat_wdata = '0;
      end else begin
         stat_we    = finish;
         stat_waddr = set_ff;
         stat_wdata = stat_wr;
      end
   end

   assign way_ext = {{WAY_OUT_W{1'b0}}, sel_way};

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (full_miss) begin
               state_in = ST_SRCH;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SRCH: begin
            if (srch_done && out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clr_busy_ff) begin
            if (clr_idx_ff == SET_AW'(SETS - 1)) begin
               clr_busy_ff <= 1'b0;
            end else begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
            end
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: hold the request, load the result at finish
   always_ff @(posedge clock) begin
      if (accept) begin
         req_addr_ff <= req_block_address;
         req_tid_ff  <= req_thread_id;
         req_cat_ff  <= req_access_category;
         set_ff      <= set_of(req_block_address);
      end
      if (finish) begin
         rsp_hit_ff      <= is_hit;
         rsp_way_ff      <= way_ext[WAY_OUT_W-1:0];
         rsp_filled_ff   <= (state_ff == ST_LOOK) && !hit_any;
         rsp_ev_valid_ff <= (state_ff == ST_SRCH);
         if (state_ff == ST_SRCH) begin
            rsp_ev_addr_ff  <= old_line.addr;
            rsp_ev_hits_ff  <= old_line.hits;
            rsp_ev_owner_ff <= old_line.owner;
            rsp_ev_cat_ff   <= old_line.cat;
         end else begin
            rsp_ev_addr_ff  <= '0;
            rsp_ev_hits_ff  <= '0;
            rsp_ev_owner_ff <= '0;
            rsp_ev_cat_ff   <= '0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_way_used         = rsp_way_ff;
   assign rsp_filled_empty     = rsp_filled_ff;
   assign rsp_evicted_valid    = rsp_ev_valid_ff;
   assign rsp_evicted_address  = rsp_ev_addr_ff;
   assign rsp_evicted_hits     = rsp_ev_hits_ff;
   assign rsp_evicted_owner    = rsp_ev_owner_ff;
   assign rsp_evicted_category = rsp_ev_cat_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the set-associative LRU cache tag store.
module tb;
   import sacl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINES          = SETS * WAYS;
   localparam int HOT_SETS       = 6;
   localparam int POOL           = 22;   // more tags than ways, so full sets evict
   localparam int RANDOM_ITEMS   = 1950;
   localparam int CALM_TAIL      = 250;  // no idling once this few items remain
   localparam int TAIL_CYCLES    = 24;   // covers the eviction path and then some
   localparam int WATCHDOG_LIMIT = 5000; // several times the length of the clearing pass

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [TID_W-1:0]  tid;
      logic [CAT_W-1:0]  cat;
   } access_t;

   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way_used;
      logic                 filled_empty;
      logic                 evicted_valid;
      logic [ADDR_W-1:0]    evicted_address;
      logic [HITS_W-1:0]    evicted_hits;
      logic [TID_W-1:0]     evicted_owner;
      logic [CAT_W-1:0]     evicted_category;
   } lookup_result_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [ADDR_W-1:0]    req_block_address = '0;
   logic [TID_W-1:0]     req_thread_id = '0;
   logic [CAT_W-1:0]     req_access_category = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_hit;
   logic [WAY_OUT_W-1:0] rsp_way_used;
   logic                 rsp_filled_empty;
   logic                 rsp_evicted_valid;
   logic [ADDR_W-1:0]    rsp_evicted_address;
   logic [HITS_W-1:0]    rsp_evicted_hits;
   logic [TID_W-1:0]     rsp_evicted_owner;
   logic [CAT_W-1:0]     rsp_evicted_category;

   // Shadow copy of the tag store. Unwritten entries are never read: a line is
   // only looked at while its present bit is set.
   bit [ADDR_W-1:0]  line_tag     [LINES];
   bit               line_present [LINES];
   bit [STAMP_W-1:0] line_stamp   [LINES];
   bit [HITS_W-1:0]  line_hits    [LINES];
   bit [TID_W-1:0]   line_owner   [LINES];
   bit [CAT_W-1:0]   line_cat     [LINES];
   bit [STAMP_W-1:0] set_time     [SETS];

   access_t        pending_accesses[$];   // stimulus not yet driven
   lookup_result_t lookup_results_due[$]; // predicted results, oldest first
   access_t        cur_access;
   lookup_result_t got_rsp;
   lookup_result_t want_rsp;

   int total_items;
   int sent_cnt;
   int accept_cnt;
   int checked_cnt;
   int fail_count;
   int quiet_cycles;
   int req_gap;
   int rsp_stall;
   bit drain_wait;
   int hits_seen;
   int fills_seen;
   int evictions_seen;

   set_assoc_lru_cache_tags i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_block_address    (req_block_address),
      .req_thread_id        (req_thread_id),
      .req_access_category  (req_access_category),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_hit              (rsp_hit),
      .rsp_way_used         (rsp_way_used),
      .rsp_filled_empty     (rsp_filled_empty),
      .rsp_evicted_valid    (rsp_evicted_valid),
      .rsp_evicted_address  (rsp_evicted_address),
      .rsp_evicted_hits     (rsp_evicted_hits),
      .rsp_evicted_owner    (rsp_evicted_owner),
      .rsp_evicted_category (rsp_evicted_category)
   );

   always #4ns clock = ~clock;

   // Look up one access in the shadow store, update it the way the block does
   // and return the result the block must produce.
   function automatic lookup_result_t tag_lookup(input access_t acc);
      lookup_result_t     r;
      int unsigned        set_idx;
      int unsigned        base;
      int unsigned        victim;
      logic [STAMP_W-1:0] now_stamp;
      bit                 done;
      r = '0;
      done = 1'b0;
      set_idx = acc.addr[SET_AW-1:0];
      base = set_idx * WAYS;
      // advance the set clock first; it sticks at all ones
      if (set_time[set_idx] != STAMP_MAX) begin
         set_time[set_idx] = set_time[set_idx] + 1'b1;
      end
      now_stamp = set_time[set_idx];
      for (int w = 0; w < WAYS; w++) begin
         if (!done && line_present[base + w] && line_tag[base + w] == acc.addr) begin
            // hit: count it, take ownership, restamp; category stays
            if (line_hits[base + w] != HITS_MAX) begin
               line_hits[base + w] = line_hits[base + w] + 1'b1;
            end
            line_owner[base + w] = acc.tid;
            line_stamp[base + w] = now_stamp;
            r.hit = 1'b1;
            r.way_used = w[WAY_OUT_W-1:0];
            done = 1'b1;
            hits_seen++;
         end
      end
      if (!done) begin
         // miss: lowest empty way, else oldest stamp with the lowest way on ties
         victim = WAYS;
         for (int w = WAYS - 1; w >= 0; w--) begin
            if (!line_present[base + w]) victim = w;
         end
         if (victim != WAYS) begin
            r.filled_empty = 1'b1;
            fills_seen++;
         end else begin
            victim = 0;
            for (int w = 1; w < WAYS; w++) begin
               if (line_stamp[base + w] < line_stamp[base + victim]) victim = w;
            end
            r.evicted_valid    = 1'b1;
            r.evicted_address  = line_tag[base + victim];
            r.evicted_hits     = line_hits[base + victim];
            r.evicted_owner    = line_owner[base + victim];
            r.evicted_category = line_cat[base + victim];
            evictions_seen++;
         end
         r.way_used = victim[WAY_OUT_W-1:0];
         line_tag[base + victim]     = acc.addr;
         line_present[base + victim] = 1'b1;
         line_stamp[base + victim]   = now_stamp;
         line_hits[base + victim]    = '0;
         line_owner[base + victim]   = acc.tid;
         line_cat[base + victim]     = acc.cat;
      end
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[ADDR_W-1:0];
   endfunction

   // Place the tag bits above the set index.
   function automatic logic [ADDR_W-1:0] set_addr(input logic [ADDR_W-1:0] upper,
                                                  input int unsigned set_idx);
      logic [ADDR_W-1:0] a;
      a = upper << SET_AW;
      a[SET_AW-1:0] = set_idx[SET_AW-1:0];
      return a;
   endfunction

   function automatic string show(input lookup_result_t r);
      return $sformatf("hit=%0b way=%0d fill=%0b ev=%0b ev_addr=%h ev_hits=%0d ev_own=%0d ev_cat=%0d",
                       r.hit, r.way_used, r.filled_empty, r.evicted_valid, r.evicted_address,
                       r.evicted_hits, r.evicted_owner, r.evicted_category);
   endfunction

   // Idle only away from the tail, and leave every third window of 200 items calm.
   function automatic bit idle_ok();
      return pending_accesses.size() > CALM_TAIL && ((sent_cnt / 200) % 3) != 1;
   endfunction

   task automatic add_access(input logic [ADDR_W-1:0] addr, input int unsigned tid,
                             input int unsigned cat);
      access_t acc;
      acc.addr = addr;
      acc.tid  = tid[TID_W-1:0];
      acc.cat  = cat[CAT_W-1:0];
      pending_accesses.push_back(acc);
   endtask

   // Request driver: change inputs at the falling edge. Hold the transfer until
   // the monitor has seen it accepted, then advance to the next access.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && accept_cnt != sent_cnt) begin
         // hold: the current transfer is still waiting for req_ready
      end else if (drain_wait) begin
         // pause the sender until every predicted result has come back
         req_valid <= 1'b0;
         if (lookup_results_due.size() == 0 && accept_cnt == sent_cnt) drain_wait = 1'b0;
      end else if (req_gap != 0) begin
         req_valid <= 1'b0;
         req_gap--;
      end else if (pending_accesses.size() != 0) begin
         cur_access = pending_accesses.pop_front();
         req_block_address   <= cur_access.addr;
         req_thread_id       <= cur_access.tid;
         req_access_category <= cur_access.cat;
         req_valid           <= 1'b1;
         sent_cnt++;
         if (sent_cnt == 600 || sent_cnt == 1400) drain_wait = 1'b1;
         if (idle_ok() && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 9);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result side: stall in random bursts, none near the end.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall != 0) begin
         rsp_ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ready <= 1'b1;
         if (idle_ok() && $urandom_range(0, 4) == 0) rsp_stall = $urandom_range(1, 9);
      end
   end

   // Monitor: sample at the rising edge. Check a result against the oldest
   // prediction, then predict for a newly accepted access.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got_rsp = {rsp_hit, rsp_way_used, rsp_filled_empty, rsp_evicted_valid,
                       rsp_evicted_address, rsp_evicted_hits, rsp_evicted_owner,
                       rsp_evicted_category};
            if (lookup_results_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("%0t: result with none due: %s", $time, show(got_rsp));
            end else begin
               want_rsp = lookup_results_due.pop_front();
               checked_cnt++;
               if (got_rsp !== want_rsp) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: result %0d mismatch, expected %s", $time, checked_cnt,
                              show(want_rsp));
                     $display("%0t: result %0d mismatch, actual   %s", $time, checked_cnt,
                              show(got_rsp));
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            cur_access.addr = req_block_address;
            cur_access.tid  = req_thread_id;
            cur_access.cat  = req_access_category;
            lookup_results_due.push_back(tag_lookup(cur_access));
            accept_cnt++;
         end
         // watchdog: drop the run if nothing moves on either channel for too long
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[set_assoc_lru_cache_tags] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int                unsigned hot_sets[HOT_SETS];
      logic [ADDR_W-1:0] hot_pool[HOT_SETS][POOL];
      logic [ADDR_W-1:0] recent[4];
      logic [ADDR_W-1:0] a;
      int                pick;
      int                hs;

      // Directed: field extremes, hits that change owner but keep category.
      add_access('0, 0, 0);
      add_access('1, 63, 15);
      add_access('1, 0, 0);
      add_access('0, 63, 15);
      // Fill all ways of one set, refresh two lines, then force two evictions:
      // the oldest stamp goes first, and a refreshed line survives.
      for (int k = 1; k <= WAYS; k++) add_access(set_addr(k, 5), k, k % 16);
      add_access(set_addr(1, 5), 7, 0);
      add_access(set_addr(3, 5), 8, 1);
      add_access(set_addr(3, 5), 9, 2);
      add_access(set_addr('1, 5), 63, 15);
      add_access(set_addr(WAYS + 2, 5), 1, 3);

      // Random: most accesses reuse tags of a few hot sets so that sets fill,
      // hit and evict; the rest are new tags and cold addresses.
      for (int i = 0; i < HOT_SETS; i++) begin
         hot_sets[i] = (i == 0) ? 0 : (i == 1) ? SETS - 1 : $urandom_range(0, SETS - 1);
         for (int j = 0; j < POOL; j++) hot_pool[i][j] = set_addr(rand_addr(), hot_sets[i]);
      end
      for (int i = 0; i < 4; i++) recent[i] = hot_pool[0][i];
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         hs = $urandom_range(0, HOT_SETS - 1);
         if (pick < 68) begin
            // skew toward low pool indexes so some tags stay hot
            a = hot_pool[hs][$urandom_range(0, $urandom_range(0, POOL - 1))];
         end else if (pick < 80) begin
            a = recent[$urandom_range(0, 3)];
         end else if (pick < 92) begin
            a = set_addr(rand_addr(), hot_sets[hs]);
         end else begin
            a = rand_addr();
         end
         recent[n % 4] = a;
         add_access(a, $urandom_range(0, 63), $urandom_range(0, 15));
      end
      total_items = pending_accesses.size();

      // Hold reset, then release it at a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every access to be taken and every result to come back,
      // then let the block sit a little to catch stray results.
      while (pending_accesses.size() != 0 || accept_cnt != total_items ||
             lookup_results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d lookups, %0d results checked, %0d mismatches.",
               accept_cnt, checked_cnt, fail_count);
      $display("Saw %0d hits, %0d fills of empty ways and %0d LRU evictions.",
               hits_seen, fills_seen, evictions_seen);
      if (fail_count == 0) begin
         $display("[set_assoc_lru_cache_tags] OK");
      end else begin
         $display("[set_assoc_lru_cache_tags] ERROR");
      end
      $finish;
   end

endmodule
